// ===== rtl/poly_hash_linear_probe_table_unit_assert.svh =====
// Assertion macros for the checker file of the hash table unit.
`ifndef POLY_HASH_LINEAR_PROBE_TABLE_UNIT_ASSERT_SVH
`define POLY_HASH_LINEAR_PROBE_TABLE_UNIT_ASSERT_SVH

// Checked only outside reset.
`define PHLPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PHLPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/phlpt_pkg.sv =====
package phlpt_pkg;

  localparam int TABLE_SLOTS_DEF = 2048;
  localparam int WINDOW_DEF      = 20;

  localparam int HASH_BASE = 31;
  localparam int HASH_W    = 30;
  localparam logic [HASH_W-1:0] HASH_MOD = 30'd1000000009;

  localparam int SLOT_W      = 11;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FOUND    = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

endpackage

// ===== rtl/poly_hash_linear_probe_table_unit.sv =====
// Polynomial-hash table with linear probing. Key bytes arrive on the input stream with
// tuser = character kind and are taken one per cycle while the unit is idle; the unit
// keeps the last WINDOW of them. An end transaction (insert or search) hashes the held
// bytes as sum byte[i] * 31^i mod 1000000009, oldest byte at i = 0, then probes the slot
// table from hash mod TABLE_SLOTS upward with no wraparound. While it works the input is
// not ready. All reduction runs through one shared compare-and-subtract reducer: each held
// byte takes one multiply-add step and five reduction steps, the start slot is reduced
// from the hash by the same reducer, and each probed slot takes a read state and a check
// state because the slot memory has a registered read port. An end transaction ends in a
// state that hands the result to the output register. After reset the unit sweeps the
// slot memory to mark every slot free, with the input held not ready. A finished result
// waits in the output register, and character transactions are still taken meanwhile.
module poly_hash_linear_probe_table_unit #(
  parameter int TABLE_SLOTS = phlpt_pkg::TABLE_SLOTS_DEF,
  parameter int WINDOW      = phlpt_pkg::WINDOW_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] char_value
  input  logic [1:0]                         in_tuser,   // [1:0] kind
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [phlpt_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [10:0] slot_index,
                                                         // [40:11] key_hash, rest zero
  output logic [1:0]                         out_tuser   // [1:0] status
);
  import phlpt_pkg::*;

  localparam int SW       = $clog2(TABLE_SLOTS);
  localparam int LW       = $clog2(WINDOW + 1);
  localparam int ACC_W    = 36;
  localparam int KW       = 5;
  localparam int K_MOD    = HASH_W - SW;
  localparam int K_HASH   = 4;
  localparam int ENTRY_W  = HASH_W + 1;
  localparam int PAD_W    = OUT_TDATA_W - HASH_W - SLOT_W;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_MAC   = 8'b0000_0100,
    S_RED   = 8'b0000_1000,
    S_MOD   = 8'b0001_0000,
    S_RD    = 8'b0010_0000,
    S_CHK   = 8'b0100_0000,
    S_RES   = 8'b1000_0000
  } state_t;

  state_t               state_r, state_nxt;
  logic [7:0]           win_r [WINDOW];
  logic [7:0]           win_nxt [WINDOW];
  logic [LW-1:0]        len_r, len_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [HASH_W-1:0]    hash_r, hash_nxt;
  logic                 insert_r, insert_nxt;
  logic [SW-1:0]        pos_r, pos_nxt;
  logic [SW-1:0]        clr_r, clr_nxt;
  status_t              res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]    res_slot_r, res_slot_nxt;

  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [1:0]           out_tuser_r, out_tuser_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // Slot memory: bit HASH_W is the occupied flag
  logic [ENTRY_W-1:0]   mem [TABLE_SLOTS];
  logic                 mem_we;
  logic [SW-1:0]        mem_wa;
  logic [ENTRY_W-1:0]   mem_wd;
  logic [ENTRY_W-1:0]   mem_rd_r;

  // Shared reducer
  logic [ACC_W-1:0]     cs_div;
  logic [ACC_W-1:0]     cs_out;
  logic [ACC_W-1:0]     mac;
  logic [SW+SLOT_W-1:0] pos_ext;
  logic                 hit;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem[pos_r];
  end

  always_comb begin
    if (state_r == S_RED) begin
      cs_div = ACC_W'(HASH_MOD) << k_r;
    end else begin
      cs_div = ACC_W'(TABLE_SLOTS) << k_r;
    end
    cs_out = (acc_r >= cs_div) ? (acc_r - cs_div) : acc_r;
    mac    = ({{(ACC_W-HASH_W){1'b0}}, acc_r[HASH_W-1:0]} * ACC_W'(HASH_BASE))
             + ACC_W'(win_r[0]);
  end

  assign pos_ext = {{SLOT_W{1'b0}}, pos_r};
  assign hit     = mem_rd_r[HASH_W] && (mem_rd_r[HASH_W-1:0] == hash_r);

  always_comb begin
    state_nxt      = state_r;
    win_nxt        = win_r;
    len_nxt        = len_r;
    acc_nxt        = acc_r;
    k_nxt          = k_r;
    hash_nxt       = hash_r;
    insert_nxt     = insert_r;
    pos_nxt        = pos_r;
    clr_nxt        = clr_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tuser_nxt  = out_tuser_r;
    out_tdata_nxt  = out_tdata_r;
    in_tready      = 1'b0;
    mem_we         = 1'b0;
    mem_wa         = pos_r;
    mem_wd         = {1'b1, hash_r};

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == SW'(TABLE_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_tuser)
            KIND_CHAR: begin
              // newest byte sits at index 0, the oldest drops off the top
              win_nxt[0] = in_tdata;
              for (int j = 1; j < WINDOW; j++) begin
                win_nxt[j] = win_r[j-1];
              end
              if (len_r < LW'(WINDOW)) begin
                len_nxt = len_r + 1'b1;
              end
            end
            KIND_INSERT, KIND_SEARCH: begin
              insert_nxt = (in_tuser == KIND_INSERT);
              acc_nxt    = '0;
              if (len_r == '0) begin
                hash_nxt  = '0;
                k_nxt     = KW'(K_MOD);
                state_nxt = S_MOD;
              end else begin
                state_nxt = S_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      S_MAC: begin
        // Horner step from the newest byte; shift zeros in so the window ends cleared
        acc_nxt = mac;
        for (int j = 0; j < WINDOW - 1; j++) begin
          win_nxt[j] = win_r[j+1];
        end
        win_nxt[WINDOW-1] = '0;
        len_nxt   = len_r - 1'b1;
        k_nxt     = KW'(K_HASH);
        state_nxt = S_RED;
      end
      S_RED: begin
        acc_nxt = cs_out;
        if (k_r == '0) begin
          if (len_r == '0) begin
            hash_nxt  = cs_out[HASH_W-1:0];
            k_nxt     = KW'(K_MOD);
            state_nxt = S_MOD;
          end else begin
            state_nxt = S_MAC;
          end
        end else begin
          k_nxt = k_r - 1'b1;
        end
      end
      S_MOD: begin
        acc_nxt = cs_out;
        if (k_r == '0) begin
          pos_nxt   = cs_out[SW-1:0];
          state_nxt = S_RD;
        end else begin
          k_nxt = k_r - 1'b1;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (insert_r && !mem_rd_r[HASH_W]) begin
          mem_we         = 1'b1;
          res_status_nxt = ST_INSERTED;
          res_slot_nxt   = pos_ext[SLOT_W-1:0];
          state_nxt      = S_RES;
        end else if (!insert_r && hit) begin
          res_status_nxt = ST_FOUND;
          res_slot_nxt   = pos_ext[SLOT_W-1:0];
          state_nxt      = S_RES;
        end else if (pos_r == SW'(TABLE_SLOTS - 1)) begin
          res_status_nxt = insert_r ? ST_FULL : ST_MISSING;
          res_slot_nxt   = '0;
          state_nxt      = S_RES;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RES: begin
        // hold until the output register is free
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = res_status_r;
          out_tdata_nxt  = {{PAD_W{1'b0}}, hash_r, res_slot_r};
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      len_r        <= '0;
      clr_r        <= '0;
      out_tvalid_r <= 1'b0;
      for (int j = 0; j < WINDOW; j++) begin
        win_r[j] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      clr_r        <= clr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      win_r        <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r        <= acc_nxt;
    k_r          <= k_nxt;
    hash_r       <= hash_nxt;
    insert_r     <= insert_nxt;
    pos_r        <= pos_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_tuser_r  <= out_tuser_nxt;
    out_tdata_r  <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

endmodule

// ===== rtl/phlpt_checker.sv =====
`include "poly_hash_linear_probe_table_unit_assert.svh"

module phlpt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [1:0]                         in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [phlpt_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [1:0]                         out_tuser
);
  import phlpt_pkg::*;

  logic                   end_take;
  logic                   out_stall;
  logic                   out_miss;
  logic [OUT_TDATA_W+1:0] out_word;

  assign end_take  = in_tvalid && in_tready &&
                     (in_tuser == KIND_INSERT || in_tuser == KIND_SEARCH);
  assign out_stall = out_tvalid && !out_tready;
  assign out_miss  = out_tvalid && (out_tuser == ST_FULL || out_tuser == ST_MISSING);
  assign out_word  = {out_tdata, out_tuser};

  // Reset starts the slot sweep: nothing taken, nothing offered
  `PHLPT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !in_tready && !out_tvalid, "busy after reset")

  // An end transaction blocks the input while it is worked on
  `PHLPT_ASSERT(a_end_blocks, end_take |=> !in_tready, "ready right after end transaction")

  // A stalled result holds
  `PHLPT_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_word), "stalled result changed")

  // A miss or a full table reports slot zero
  `PHLPT_ASSERT(a_miss_slot, out_miss |-> out_tdata[SLOT_W-1:0] == '0, "miss with non-zero slot")

endmodule

bind poly_hash_linear_probe_table_unit phlpt_checker u_phlpt_checker (.*);

// ===== tb/poly_hash_linear_probe_table_unit_tb.sv =====
module poly_hash_linear_probe_table_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import phlpt_pkg::*;

  localparam int SLOTS = TABLE_SLOTS_DEF;
  localparam int WIN = WINDOW_DEF;
  localparam int ITEM_TARGET = 1000;
  localparam int STALL_LIMIT = 30000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    status_t          status;
    logic [SLOT_W-1:0] slot;
    logic [HASH_W-1:0] hash;
  } lookup_t;

  class probe_table_scoreboard;
    logic [7:0]        key_bytes[WIN];
    int unsigned       held;
    bit                slot_used[SLOTS];
    logic [HASH_W-1:0] slot_hash[SLOTS];
    lookup_t           expected_lookups[$];
    int unsigned       errors;
    int unsigned       results_seen;
    int unsigned       status_count[4];

    function new();
      clear_key();
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_hash[i] = '0;
      end
      errors = 0;
      results_seen = 0;
      for (int i = 0; i < 4; i++) status_count[i] = 0;
    endfunction

    function void clear_key();
      for (int i = 0; i < WIN; i++) key_bytes[i] = 8'h00;
      held = 0;
    endfunction

    // Oldest byte carries 31^0.
    function logic [HASH_W-1:0] window_poly_hash();
      longint unsigned acc;
      longint unsigned pw;
      longint unsigned modulus;
      modulus = longint'(HASH_MOD);
      acc = 0;
      pw = 1;
      for (int i = 0; i < held; i++) begin
        acc = (acc + longint'(key_bytes[i]) * pw) % modulus;
        pw = (pw * HASH_BASE) % modulus;
      end
      return acc[HASH_W-1:0];
    endfunction

    function int pending();
      return expected_lookups.size();
    endfunction

    function void note_input(kind_t k, logic [7:0] c);
      lookup_t          res;
      logic [HASH_W-1:0] h;
      int               pos;
      case (k)
        KIND_CHAR: begin
          if (held < WIN) begin
            key_bytes[held] = c;
            held++;
          end else begin
            for (int i = 0; i < WIN - 1; i++) key_bytes[i] = key_bytes[i+1];
            key_bytes[WIN-1] = c;
          end
        end
        KIND_INSERT, KIND_SEARCH: begin
          h = window_poly_hash();
          res.hash = h;
          res.slot = '0;
          res.status = (k == KIND_INSERT) ? ST_FULL : ST_MISSING;
          // Probe upward from the home slot; no wraparound.
          for (pos = int'(h % SLOTS); pos < SLOTS; pos++) begin
            if (k == KIND_INSERT && !slot_used[pos]) begin
              slot_used[pos] = 1'b1;
              slot_hash[pos] = h;
              res.status = ST_INSERTED;
              res.slot = pos[SLOT_W-1:0];
              break;
            end
            if (k == KIND_SEARCH && slot_used[pos] && slot_hash[pos] == h) begin
              res.status = ST_FOUND;
              res.slot = pos[SLOT_W-1:0];
              break;
            end
          end
          expected_lookups.insert(expected_lookups.size(), res);
          clear_key();
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      if (errors < 30) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(status_t s, logic [SLOT_W-1:0] slot, logic [HASH_W-1:0] h);
      lookup_t want;
      results_seen++;
      status_count[s]++;
      if (expected_lookups.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %s slot %0d hash %0d",
                                  s.name(), slot, h));
      end else begin
        want = expected_lookups.pop_front();
        if (s !== want.status)
          report_mismatch($sformatf("status %s, want %s", s.name(), want.status.name()));
        if (slot !== want.slot)
          report_mismatch($sformatf("slot_index %0d, want %0d", slot, want.slot));
        if (h !== want.hash)
          report_mismatch($sformatf("key_hash %0d, want %0d", h, want.hash));
      end
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;
  logic [1:0]             in_tuser = KIND_CHAR;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;

  probe_table_scoreboard sb = new();

  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 74;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  int unsigned long_keys = 0;
  int unsigned noise_items = 0;

  logic [WIN*8-1:0] known_win[$];
  int               known_len[$];

  poly_hash_linear_probe_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor both channels on the pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready || out_tvalid && out_tready) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (in_tvalid && in_tready) sb.note_input(kind_t'(in_tuser), in_tdata);
      if (out_tvalid && out_tready)
        sb.check_result(status_t'(out_tuser), out_tdata[SLOT_W-1:0],
                        out_tdata[SLOT_W +: HASH_W]);
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  task automatic send_item(input kind_t k, input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= k;
    in_tdata <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (k != KIND_NONE) items_sent++;
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic send_key(input logic [7:0] kb[32], input int len, input kind_t end_kind);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4) begin
        send_item(KIND_NONE, 8'($urandom_range(255)));
        noise_items++;
      end
      send_item(KIND_CHAR, kb[i]);
    end
    send_item(end_kind, 8'($urandom_range(255)));
  endtask

  task automatic run_random(input int unsigned upto);
    logic [7:0]       kb[32];
    logic [WIN*8-1:0] win;
    int               len;
    int               pick;
    int               start;
    kind_t            end_kind;
    while (items_sent < upto) begin
      if (known_win.size() != 0 && $urandom_range(99) < 45) begin
        // Replay a stored key, mostly to search for it.
        pick = $urandom_range(known_win.size() - 1);
        len = known_len[pick];
        for (int i = 0; i < len; i++) kb[i] = known_win[pick][8*i +: 8];
        end_kind = ($urandom_range(99) < 75) ? KIND_SEARCH : KIND_INSERT;
        send_key(kb, len, end_kind);
      end else begin
        case ($urandom_range(19))
          0:       len = 0;
          1, 2:    len = $urandom_range(WIN + 6, WIN - 2);
          default: len = $urandom_range(8, 1);
        endcase
        if (len > WIN) long_keys++;
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(9))
            0:       kb[i] = 8'h00;
            1:       kb[i] = 8'hFF;
            default: kb[i] = 8'($urandom_range(255));
          endcase
        end
        end_kind = ($urandom_range(99) < 70) ? KIND_INSERT : KIND_SEARCH;
        send_key(kb, len, end_kind);
        if (end_kind == KIND_INSERT) begin
          start = (len > WIN) ? len - WIN : 0;
          win = '0;
          for (int i = 0; i < len - start; i++) win[8*i +: 8] = kb[start + i];
          known_win.insert(known_win.size(), win);
          known_len.insert(known_len.size(), len - start);
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty key: hash 0, home slot 0; the second insert lands next door.
    send_item(KIND_INSERT, 8'hFF);
    send_item(KIND_SEARCH, 8'h00);
    send_item(KIND_INSERT, 8'h5A);
    // 1 + 31*66 = 2047: the last slot, so a repeat insert finds no room.
    send_item(KIND_CHAR, 8'd1);
    send_item(KIND_CHAR, 8'd66);
    send_item(KIND_INSERT, 8'h00);
    send_item(KIND_CHAR, 8'd1);
    send_item(KIND_NONE, 8'hAA);
    noise_items++;
    send_item(KIND_CHAR, 8'd66);
    send_item(KIND_INSERT, 8'hFF);
    send_item(KIND_CHAR, 8'd1);
    send_item(KIND_CHAR, 8'd66);
    send_item(KIND_SEARCH, 8'h00);
    // Never inserted: scan to the end of the table.
    send_item(KIND_CHAR, 8'h00);
    send_item(KIND_CHAR, 8'hFF);
    send_item(KIND_SEARCH, 8'hFF);
    send_item(KIND_CHAR, 8'hFF);
    send_item(KIND_SEARCH, 8'h00);
    drain_results();

    run_random(ITEM_TARGET / 3);
    drain_results();

    send_idle_pct = 74;
    recv_idle_pct = 26;
    run_random(2 * ITEM_TARGET / 3);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ITEM_TARGET);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d items (%0d long keys, %0d ignored items); %0d results checked",
             items_sent, long_keys, noise_items, sb.results_seen);
    $display("results: %0d inserted, %0d table full, %0d found, %0d not found",
             sb.status_count[ST_INSERTED], sb.status_count[ST_FULL],
             sb.status_count[ST_FOUND], sb.status_count[ST_MISSING]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/phlpt_pkg.sv
rtl/poly_hash_linear_probe_table_unit.sv
rtl/phlpt_checker.sv
tb/poly_hash_linear_probe_table_unit_tb.sv
